// ===== hw/rtl/sje_pkg.sv =====
// Shared types and constants for the semi join engine.
// No dependencies; imported by sje_ctrl, sje_dp, semi_join_engine and tb_top.
`default_nettype none
package sje_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;

  localparam int OPCODE_W   = 2;
  localparam int JOIN_KEY_W = 32;
  localparam int POS_W      = 6;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ANTI_MODE = 1'b0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BUILD  = 2'd0,
    OP_PROBE  = 2'd1,
    OP_FINISH = 2'd2
  } opcode_t;

  typedef struct packed {
    logic take;
    logic scan_step;
    logic end_step;
  } sje_cmd_t;

  typedef struct packed {
    opcode_t in_op;
    logic    anti_mode;
    logic    slot_free;
    logic    scan_end;
  } sje_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sje_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sje_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sje_ctrl.sv =====
// Controller state machine of the semi join engine.
// Depends on sje_pkg; drives commands to sje_dp from its status.
`default_nettype none
module sje_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire sje_pkg::sje_sts_t sts,
  output sje_pkg::sje_cmd_t      cmd
);
  import sje_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DONE
  } state_t;

  state_t state;

  assign s_tready      = (state == IDLE);
  assign cmd.take      = (state == IDLE) && s_tvalid;
  assign cmd.scan_step = (state == SCAN) && sts.slot_free;
  assign cmd.end_step  = (state == DONE) && sts.slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            case (sts.in_op)
              OP_PROBE:  state <= SCAN;
              OP_FINISH: state <= sts.anti_mode ? SCAN : DONE;
              default:   state <= IDLE;
            endcase
          end
        end
        SCAN: begin
          if (sts.slot_free && sts.scan_end) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (sts.slot_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sje_dp.sv =====
// Datapath: key RAM, match flags, entry count, scan pipeline, output register.
// Depends on sje_pkg and sje_ram; commanded by sje_ctrl.
`default_nettype none
module sje_dp #(
  parameter int TABLE_DEPTH = sje_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = sje_pkg::KEY_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sje_pkg::sje_cmd_t              cmd,
  output sje_pkg::sje_sts_t                   sts,
  input  wire logic                           anti_mode,
  input  wire logic [sje_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [sje_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                                m_tlast,
  output logic                                m_tuser
);
  import sje_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W  = (KEY_BITS < JOIN_KEY_W) ? KEY_BITS : JOIN_KEY_W;

  opcode_t               in_op;
  logic [KEY_W-1:0]      in_key;
  opcode_t               op_reg;
  logic [KEY_W-1:0]      key_reg;
  logic [CNT_W-1:0]      count;
  logic [TABLE_DEPTH-1:0] flags;
  logic [CNT_W-1:0]      idx;
  logic                  cmp_valid;
  logic [ADDR_W-1:0]     cmp_idx;
  logic                  pend_valid;
  logic [ADDR_W-1:0]     pend_pos;
  logic [POS_W-1:0]      out_pos;
  logic                  full;
  logic                  issue;
  logic                  we;
  logic [KEY_W-1:0]      rd_data;
  logic                  hit;
  logic                  emit;
  logic                  load;
  logic [POS_W-1:0]      load_pos;
  logic                  load_last;
  logic                  load_none;

  assign in_op  = opcode_t'(s_tdata[OPCODE_W-1:0]);
  assign in_key = s_tdata[OPCODE_W +: KEY_W];
  assign full   = (count == CNT_W'(TABLE_DEPTH));
  assign issue  = (idx < count);
  assign we     = cmd.take && (in_op == OP_BUILD) && !full;

  sje_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(in_key),
    .re   (cmd.scan_step),
    .raddr(idx[ADDR_W-1:0]),
    .rdata(rd_data)
  );

  assign sts.in_op     = in_op;
  assign sts.anti_mode = anti_mode;
  assign sts.slot_free = !m_tvalid || m_tready;
  assign sts.scan_end  = !issue;

  always_comb begin
    hit = cmp_valid && !flags[cmp_idx];
    if (op_reg == OP_PROBE) begin
      hit  = hit && (rd_data == key_reg);
      emit = hit && !anti_mode;
    end else begin
      emit = hit && anti_mode;
    end
  end

  always_comb begin
    load      = 1'b0;
    load_pos  = POS_W'(pend_pos);
    load_last = 1'b0;
    load_none = 1'b0;
    if (cmd.scan_step && emit && pend_valid) begin
      load = 1'b1;
    end else if (cmd.end_step) begin
      if (pend_valid) begin
        load      = 1'b1;
        load_last = 1'b1;
      end else if (op_reg == OP_FINISH) begin
        load      = 1'b1;
        load_pos  = '0;
        load_last = 1'b1;
        load_none = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      flags      <= '0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      idx        <= '0;
    end else begin
      if (cmd.take) begin
        op_reg    <= in_op;
        key_reg   <= in_key;
        idx       <= '0;
        cmp_valid <= 1'b0;
        if (we) begin
          flags[count[ADDR_W-1:0]] <= 1'b0;
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.scan_step) begin
        cmp_valid <= issue;
        cmp_idx   <= idx[ADDR_W-1:0];
        if (issue) begin
          idx <= idx + CNT_W'(1);
        end
        if (hit && op_reg == OP_PROBE) begin
          flags[cmp_idx] <= 1'b1;
        end
        if (emit) begin
          pend_valid <= 1'b1;
          pend_pos   <= cmp_idx;
        end
      end
      if (cmd.end_step) begin
        pend_valid <= 1'b0;
        if (op_reg == OP_FINISH) begin
          flags <= '0;
          count <= '0;
        end
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pos <= load_pos;
      m_tlast <= load_last;
      m_tuser <= load_none;
    end
  end

  assign m_tdata = M_TDATA_W'(out_pos);

endmodule
`default_nettype wire

// ===== hw/rtl/semi_join_engine.sv =====
// Semi join / anti semi join engine: top level with the APB register.
// Depends on sje_pkg, sje_ctrl, sje_dp (and sje_ram below it).
//
// Input stream (s_*): opcode build, probe or finish with a join key. A build
// stores the key at the next position (ignored when the table is full). A
// probe reads the stored keys from the key RAM one per cycle while the
// receiver does not stall; in semi mode it streams the positions it newly
// matched, ascending, the last beat with tlast. A finish in anti mode scans
// the match flags the same way and streams the unmatched positions; in semi
// mode, or when none are unmatched, it sends one beat with tuser (none_found)
// and tlast set. A finish empties the table. Build and unused opcodes send
// nothing. A found position is held back so tlast can be set: its beat is
// loaded when the next one is found, the final one when the scan ends.
// Output (m_*) is registered; when the receiver stalls the scan halts and
// holds its place, and a waiting result does not block acceptance of the
// next item. Reset empties the table, clears all match flags and selects
// semi mode. anti_mode is at APB byte address 0.
`default_nettype none
module semi_join_engine #(
  parameter int TABLE_DEPTH = sje_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = sje_pkg::KEY_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [sje_pkg::S_TDATA_W-1:0]   s_tdata,   // opcode[1:0], join_key[33:2]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [sje_pkg::M_TDATA_W-1:0]   m_tdata,   // position[5:0]
  output logic                                 m_tlast,
  output logic                                 m_tuser,   // none_found[0]
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sje_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [sje_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [sje_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import sje_pkg::*;

  logic     anti_mode;
  logic     reg_sel;
  sje_cmd_t cmd;
  sje_sts_t sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_ANTI_MODE) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_sel ? APB_DATA_W'(anti_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      anti_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ANTI_MODE) begin
      anti_mode <= pwdata[0];
    end
  end

  sje_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  sje_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .anti_mode(anti_mode),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for semi_join_engine: a scoreboard class predicts the semi and
// anti semi join result beats, and plain tasks drive the stream and APB ports.
// Depends on sje_pkg and the semi_join_engine RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sje_pkg::*;

  localparam int TBL = TABLE_DEPTH_DEF;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] ADDR_ANTI_MODE = '0;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last;
    logic             none_found;
  } join_result_t;

  class join_scoreboard;
    logic [JOIN_KEY_W-1:0] key_by_pos [TBL];
    bit                    hit_by_pos [TBL];
    int unsigned           entries;
    bit                    anti;
    join_result_t          due_results [$];
    int unsigned           errors;
    int unsigned           items_seen;
    int unsigned           beats_seen;
    int unsigned           markers_seen;

    function new();
      entries = 0;
      anti = 1'b0;
      errors = 0;
      items_seen = 0;
      beats_seen = 0;
      markers_seen = 0;
      foreach (hit_by_pos[i]) hit_by_pos[i] = 1'b0;
    endfunction

    function void set_mode(bit m);
      anti = m;
    endfunction

    function void push_positions(int pos_list [$], bit marker_if_none);
      join_result_t r;
      for (int j = 0; j < pos_list.size(); j++) begin
        r.position = pos_list[j][POS_W-1:0];
        r.last = (j == pos_list.size() - 1);
        r.none_found = 1'b0;
        due_results = {due_results, r};
      end
      if (pos_list.size() == 0 && marker_if_none) begin
        r.position = '0;
        r.last = 1'b1;
        r.none_found = 1'b1;
        due_results = {due_results, r};
      end
    endfunction

    function void match_item(logic [OPCODE_W-1:0] op, logic [JOIN_KEY_W-1:0] key);
      int pos_list [$];
      items_seen++;
      case (op)
        OP_BUILD: begin
          if (entries < TBL) begin
            key_by_pos[entries] = key;
            hit_by_pos[entries] = 1'b0;
            entries++;
          end
        end
        OP_PROBE: begin
          for (int i = 0; i < entries; i++) begin
            if (key_by_pos[i] == key && !hit_by_pos[i]) begin
              hit_by_pos[i] = 1'b1;
              if (!anti) pos_list = {pos_list, i};
            end
          end
          push_positions(pos_list, 1'b0);
        end
        OP_FINISH: begin
          if (anti) begin
            for (int i = 0; i < entries; i++)
              if (!hit_by_pos[i]) pos_list = {pos_list, i};
          end
          push_positions(pos_list, 1'b1);
          foreach (hit_by_pos[i]) hit_by_pos[i] = 1'b0;
          entries = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [POS_W-1:0] position, logic last, logic none_found);
      join_result_t e;
      beats_seen++;
      if (none_found) markers_seen++;
      if (due_results.size() == 0) begin
        $error("unexpected result beat: position %0d last %0b none_found %0b",
               position, last, none_found);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (position !== e.position) begin
        $error("position: expected %0d, actual %0d", e.position, position);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, last);
        errors++;
      end
      if (none_found !== e.none_found) begin
        $error("none_found: expected %0b, actual %0b", e.none_found, none_found);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // opcode[1:0], join_key[33:2]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;       // position[5:0]
  logic                  m_tlast;
  logic                  m_tuser;       // none_found[0]
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  join_scoreboard        board;
  int                    tx_idle_pct = 0;
  int                    rx_stall_pct = 0;
  logic [JOIN_KEY_W-1:0] key_pool [4];

  semi_join_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  always @(negedge clk) begin
    m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && board != null) begin
      if (s_tvalid && s_tready)
        board.match_item(s_tdata[OPCODE_W-1:0], s_tdata[OPCODE_W +: JOIN_KEY_W]);
      if (m_tvalid && m_tready)
        board.check_beat(m_tdata[POS_W-1:0], m_tlast, m_tuser);
    end
  end

  // entered and left at a falling edge
  task automatic put_item(logic [OPCODE_W-1:0] op, logic [JOIN_KEY_W-1:0] key);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= S_TDATA_W'({$urandom, $urandom});
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_TDATA_W - JOIN_KEY_W - OPCODE_W){1'b0}}, key, op};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ANTI_MODE) board.set_mode(data[0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // probe and anti-mode scans can run with no result pending
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.due_results.size() != 0) @(negedge clk);
    repeat (TBL + 16) @(negedge clk);
  endtask

  task automatic set_mode(bit m);
    wait_idle();
    reg_write(ADDR_ANTI_MODE, {31'($urandom), m});
  endtask

  function automatic logic [JOIN_KEY_W-1:0] pick_key(int n);
    if (n == 1) return key_pool[0];
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(n - 1)];
    return $urandom;
  endfunction

  task automatic noise();
    int r;
    r = $urandom_range(99);
    if (r < 8) put_item(OP_UNUSED, $urandom);
    else if (r < 12) put_item(OP_PROBE, $urandom);
  endtask

  task automatic run_sequence(int nbuild, int pool_n);
    int nprobe;
    int r;
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(9);
      key_pool[i] = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
    end
    repeat (nbuild) begin
      noise();
      put_item(OP_BUILD, pick_key(pool_n));
    end
    nprobe = $urandom_range(0, 6);
    repeat (nprobe) begin
      noise();
      put_item(OP_PROBE, pick_key(pool_n));
    end
    if ($urandom_range(99) < 85) put_item(OP_FINISH, $urandom);
  endtask

  initial begin
    int idle_tx [4];
    int idle_rx [4];
    int start_items;
    idle_tx = '{0, 60, 0, 36};
    idle_rx = '{0, 0, 60, 36};
    board = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // semi mode: empty finish, duplicates, extremes, repeated probe, unused opcode
    set_mode(1'b0);
    put_item(OP_FINISH, '1);
    put_item(OP_BUILD, '0);
    put_item(OP_BUILD, '1);
    put_item(OP_BUILD, '0);
    put_item(OP_BUILD, 32'h1234_5678);
    put_item(OP_PROBE, '0);
    put_item(OP_PROBE, '0);
    put_item(OP_PROBE, '1);
    put_item(OP_PROBE, 32'h5A5A_A5A5);
    put_item(OP_UNUSED, 32'h1234_5678);
    put_item(OP_FINISH, '0);

    // anti mode: unmatched drain, all matched, empty table
    set_mode(1'b1);
    put_item(OP_BUILD, 32'h0000_00FF);
    put_item(OP_BUILD, 32'hFF00_0000);
    put_item(OP_BUILD, 32'h0000_00FF);
    put_item(OP_PROBE, 32'h0000_00FF);
    put_item(OP_FINISH, '0);
    put_item(OP_BUILD, 32'hA5A5_5A5A);
    put_item(OP_BUILD, 32'hA5A5_5A5A);
    put_item(OP_PROBE, 32'hA5A5_5A5A);
    put_item(OP_FINISH, '1);
    put_item(OP_FINISH, 32'h8000_0001);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      tx_idle_pct = idle_tx[ph];
      rx_stall_pct = idle_rx[ph];
      set_mode(ph[0]);
      start_items = board.items_seen;
      if (ph == 1) run_sequence(TBL + 2, 4);
      if (ph == 2) run_sequence(TBL + 1, 1);
      while (board.items_seen - start_items < 20) begin
        run_sequence(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 9), 4);
        if ($urandom_range(99) < 20) set_mode(1'($urandom_range(1)));
      end
    end

    wait_idle();
    $display("tb_top: %0d input beats, %0d result beats checked (%0d none_found markers)",
             board.items_seen, board.beats_seen, board.markers_seen);
    $display("tb_top: both modes, full table, mode switches mid-run, idle and stall phases");
    if (board.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sje_pkg.sv
hw/rtl/sje_ram.sv
hw/rtl/sje_ctrl.sv
hw/rtl/sje_dp.sv
hw/rtl/semi_join_engine.sv
tb/tb_top.sv
